@@ sv/itp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the integer text parser
// Character classes, parse phases, register map and the control state
// struct passed between the parser modules.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned SIZE_W  = 2;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned CFG_AW  = 4;

  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_WS_LO  = 8'd9;
  localparam logic [CHAR_W-1:0] CH_WS_HI  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic               SIGNED_RESET = 1'b1;
  localparam logic [SIZE_W-1:0]  SIZE_RESET   = 2'd3;

  typedef enum logic [1:0] {
    REG_RADIX  = 2'd0,
    REG_SIGNED = 2'd1,
    REG_SIZE   = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [SIZE_W-1:0] {
    SIZE_8  = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_32 = 2'd2,
    SIZE_64 = 2'd3
  } size_t;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_TRAIL = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   failed;
    logic   minus;
  } ctrl_t;

  typedef struct packed {
    logic               hit;
    logic [RADIX_W-1:0] val;
  } digit_t;

  function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
    digit_t d;
    logic [CHAR_W-1:0] v;
    d.hit = 1'b1;
    v     = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      v = c - CH_LC_A + LETTER_BASE;
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      v = c - CH_UC_A + LETTER_BASE;
    end else begin
      d.hit = 1'b0;
    end
    d.val = v[RADIX_W-1:0];
    return d;
  endfunction

endpackage
`default_nettype wire

@@ sv/itp_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itp_step: next parse state for one character
// Classifies the character, runs the phase rules and folds a digit into
// the magnitude with an overflow check against the accumulator limit.
// ----------------------------------------------------------------------------
module itp_step #(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  wire itp_pkg::ctrl_t                 st,
  input  wire logic [ACC_WIDTH-1:0]           mag,
  input  wire logic [itp_pkg::CHAR_W-1:0]     ch,
  input  wire logic [itp_pkg::RADIX_W-1:0]    radix,
  input  wire logic                           signed_mode,
  output itp_pkg::ctrl_t                      st_nxt,
  output logic [ACC_WIDTH-1:0]                mag_nxt
);

  localparam int unsigned PW = ACC_WIDTH + itp_pkg::RADIX_W;
  localparam logic [ACC_WIDTH-1:0] UMAX = {ACC_WIDTH{1'b1}};

  itp_pkg::digit_t      dig;
  logic                 d_ok;
  logic                 is_ws;
  logic [ACC_WIDTH-1:0] lim;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        sum;
  logic                 ovf;

  assign dig   = itp_pkg::digit_of(ch);
  assign d_ok  = dig.hit && (dig.val < radix);
  assign is_ws = ch inside {[itp_pkg::CH_WS_LO:itp_pkg::CH_WS_HI]};
  assign lim   = signed_mode ? ((UMAX >> 1) + ACC_WIDTH'(st.minus)) : UMAX;
  assign prod  = PW'(mag) * PW'(radix);
  assign sum   = prod + PW'(dig.val);
  assign ovf   = sum > PW'(lim);

  always_comb begin
    st_nxt  = st;
    mag_nxt = mag;
    if (!st.failed) begin
      case (st.phase)
        itp_pkg::PH_LEAD: begin
          if (is_ws) begin
            st_nxt = st;
          end else if (ch == itp_pkg::CH_MINUS && signed_mode) begin
            st_nxt.minus = 1'b1;
            st_nxt.phase = itp_pkg::PH_SIGN;
          end else if (ch == itp_pkg::CH_PLUS) begin
            st_nxt.phase = itp_pkg::PH_SIGN;
          end else if (d_ok) begin
            if (ovf) begin
              st_nxt.failed = 1'b1;
            end else begin
              mag_nxt      = sum[ACC_WIDTH-1:0];
              st_nxt.phase = itp_pkg::PH_DIGIT;
            end
          end else begin
            st_nxt.failed = 1'b1;
          end
        end
        itp_pkg::PH_SIGN, itp_pkg::PH_DIGIT: begin
          if (d_ok) begin
            if (ovf) begin
              st_nxt.failed = 1'b1;
            end else begin
              mag_nxt      = sum[ACC_WIDTH-1:0];
              st_nxt.phase = itp_pkg::PH_DIGIT;
            end
          end else if (is_ws && st.phase == itp_pkg::PH_DIGIT) begin
            st_nxt.phase = itp_pkg::PH_TRAIL;
          end else begin
            st_nxt.failed = 1'b1;
          end
        end
        default: begin
          if (!is_ws) begin
            st_nxt.failed = 1'b1;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/itp_result.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itp_result: end-of-string check
// Validates the final phase, sign mode, accumulator limit and target width,
// and forms the two's complement value or zero on failure.
// ----------------------------------------------------------------------------
module itp_result #(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  wire itp_pkg::ctrl_t                 st,
  input  wire logic [ACC_WIDTH-1:0]           mag,
  input  wire logic                           signed_mode,
  input  wire logic [itp_pkg::SIZE_W-1:0]     result_size,
  output logic [itp_pkg::VALUE_W-1:0]         value,
  output logic                                ok
);

  localparam int unsigned VW = itp_pkg::VALUE_W;
  localparam logic [ACC_WIDTH-1:0] UMAX = {ACC_WIDTH{1'b1}};

  logic [ACC_WIDTH-1:0] acc_lim;
  logic [VW-1:0]        m64;
  logic [VW-1:0]        neg_add;
  logic                 fits;

  assign acc_lim = signed_mode ? ((UMAX >> 1) + ACC_WIDTH'(st.minus)) : UMAX;
  assign m64     = VW'(mag);
  assign neg_add = VW'(st.minus);

  always_comb begin
    case (itp_pkg::size_t'(result_size))
      itp_pkg::SIZE_8:
        fits = signed_mode ? (m64 <= VW'(8'h7F) + neg_add) : (m64 <= VW'(8'hFF));
      itp_pkg::SIZE_16:
        fits = signed_mode ? (m64 <= VW'(16'h7FFF) + neg_add) : (m64 <= VW'(16'hFFFF));
      itp_pkg::SIZE_32:
        fits = signed_mode ? (m64 <= VW'(32'h7FFF_FFFF) + neg_add)
                           : (m64 <= VW'(32'hFFFF_FFFF));
      default:
        fits = 1'b1;
    endcase
  end

  assign ok = !st.failed
           && (st.phase == itp_pkg::PH_DIGIT || st.phase == itp_pkg::PH_TRAIL)
           && !(st.minus && !signed_mode)
           && (mag <= acc_lim)
           && fits;

  assign value = !ok ? '0 : (st.minus ? (VW'(0) - m64) : m64);

endmodule
`default_nettype wire

@@ sv/integer_text_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// integer_text_parser: radix integer parser for a character stream
// Takes one character per transfer, ends a string on a tlast transfer (whose
// character is ignored) and returns the parsed 64-bit value with an ok flag.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  in_*     | slave     | tdata[7:0] character, tlast end of string
//  out_*    | master    | tdata[63:0] parsed value, tuser[0] ok flag
//  cfg_*    | APB       | 0x0 radix, 0x4 signed mode, 0x8 result size
//
//  One character per cycle when no result stalls; the accumulate step (one
//  narrow multiply-add and compare) sits between input and state registers.
//  The tlast transfer passes the input register, then the result register.
//  Reset restores radix 10, signed mode, 64-bit size and an empty string.
//  A stalled result holds the tlast and what follows; earlier characters flow.
// ----------------------------------------------------------------------------
module integer_text_parser #(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,    // [7:0] character
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [63:0]                         out_tdata,   // [63:0] parsed_value
  output logic [0:0]                          out_tuser,   // [0] parse_ok
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [itp_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [itp_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [itp_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                cfg_pready
);

  localparam itp_pkg::ctrl_t CTRL_CLEAR = '{phase: itp_pkg::PH_LEAD,
                                            failed: 1'b0, minus: 1'b0};

  logic [itp_pkg::RADIX_W-1:0] radix_r;
  logic                        signed_r;
  logic [itp_pkg::SIZE_W-1:0]  size_r;
  logic [itp_pkg::RADIX_W-1:0] radix_eff;
  itp_pkg::reg_idx_t           reg_idx;
  logic                        cfg_wr;

  logic                        s1_valid_r;
  logic [itp_pkg::CHAR_W-1:0]  s1_char_r;
  logic                        s1_end_r;
  logic                        s1_adv;

  itp_pkg::ctrl_t              st_r;
  itp_pkg::ctrl_t              st_step;
  logic [ACC_WIDTH-1:0]        mag_r;
  logic [ACC_WIDTH-1:0]        mag_step;

  logic                        out_valid_r;
  logic [itp_pkg::VALUE_W-1:0] out_value_r;
  logic                        out_ok_r;
  logic [itp_pkg::VALUE_W-1:0] res_value;
  logic                        res_ok;

  // configuration
  assign cfg_pready = 1'b1;
  assign reg_idx    = itp_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= itp_pkg::RADIX_RESET;
      signed_r <= itp_pkg::SIGNED_RESET;
      size_r   <= itp_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        itp_pkg::REG_RADIX:  radix_r  <= cfg_pwdata[itp_pkg::RADIX_W-1:0];
        itp_pkg::REG_SIGNED: signed_r <= cfg_pwdata[0];
        itp_pkg::REG_SIZE:   size_r   <= cfg_pwdata[itp_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      itp_pkg::REG_RADIX:  cfg_prdata = itp_pkg::CFG_DW'(radix_r);
      itp_pkg::REG_SIGNED: cfg_prdata = itp_pkg::CFG_DW'(signed_r);
      itp_pkg::REG_SIZE:   cfg_prdata = itp_pkg::CFG_DW'(size_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign radix_eff = (radix_r < itp_pkg::RADIX_MIN) ? itp_pkg::RADIX_MIN :
                     (radix_r > itp_pkg::RADIX_MAX) ? itp_pkg::RADIX_MAX : radix_r;

  // input register
  assign s1_adv    = !s1_end_r || !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_end_r  <= in_tlast;
    end
  end

  // parse state
  itp_step #(.ACC_WIDTH(ACC_WIDTH)) u_step (
    .st          (st_r),
    .mag         (mag_r),
    .ch          (s1_char_r),
    .radix       (radix_eff),
    .signed_mode (signed_r),
    .st_nxt      (st_step),
    .mag_nxt     (mag_step)
  );

  itp_result #(.ACC_WIDTH(ACC_WIDTH)) u_result (
    .st          (st_r),
    .mag         (mag_r),
    .signed_mode (signed_r),
    .result_size (size_r),
    .value       (res_value),
    .ok          (res_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= CTRL_CLEAR;
      mag_r <= '0;
    end else if (s1_valid_r && s1_adv) begin
      if (s1_end_r) begin
        st_r  <= CTRL_CLEAR;
        mag_r <= '0;
      end else begin
        st_r  <= st_step;
        mag_r <= mag_step;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_adv && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv && s1_end_r) begin
      out_value_r <= res_value;
      out_ok_r    <= res_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_ok_r;

endmodule
`default_nettype wire

@@ tb/sv/integer_text_parser_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_text_parser_tb: self-checking bench for the radix integer parser
// Streams character strings into the parser under many register settings
// and checks every result against an in-bench predictor. Random idle bursts
// on both channels and a long output stall exercise the stream handshake.
// ----------------------------------------------------------------------------
module integer_text_parser_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 30;
  localparam logic [itp_pkg::CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [63:0] NO_DIGIT = 64'd64;

  typedef struct {
    logic [itp_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } char_item_t;

  typedef struct {
    logic [63:0] value;
    logic        ok;
  } parse_result_t;

  logic                       clk;
  logic                       rst_n       = 1'b0;
  logic                       in_tvalid   = 1'b0;
  logic                       in_tready;
  logic [7:0]                 in_tdata    = '0;   // [7:0] character
  logic                       in_tlast    = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready  = 1'b0;
  logic [63:0]                out_tdata;          // [63:0] parsed_value
  logic [0:0]                 out_tuser;          // [0] parse_ok
  logic                       cfg_psel    = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite  = 1'b0;
  logic [itp_pkg::CFG_AW-1:0] cfg_paddr   = '0;
  logic [itp_pkg::CFG_DW-1:0] cfg_pwdata  = '0;
  logic [itp_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  char_item_t    char_q[$];
  parse_result_t want_q[$];

  // predictor copy of registers and parse state
  logic [itp_pkg::RADIX_W-1:0] c_radix  = itp_pkg::RADIX_RESET;
  logic                        c_signed = itp_pkg::SIGNED_RESET;
  itp_pkg::size_t              c_size   = itp_pkg::SIZE_64;
  itp_pkg::phase_t             p_phase  = itp_pkg::PH_LEAD;
  logic                        p_failed = 1'b0;
  logic                        p_minus  = 1'b0;
  logic [63:0]                 p_mag    = '0;

  logic calm       = 1'b0;
  logic press_on   = 1'b0;
  logic press_done = 1'b0;
  int   tx_gap     = 0;
  int   rx_gap     = 0;
  int   hold_cnt   = 0;
  int   cycle_count = 0;
  int   errors     = 0;
  int   pushed     = 0;
  int   chars_in   = 0;
  int   strings_done = 0;
  int   cfg_writes = 0;
  int   radix_tab[12] = '{2, 36, 10, 16, 0, 63, 1, 37, 8, 3, 35, 7};

  integer_text_parser u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // ---------------- predictor ----------------
  function automatic logic [63:0] acc_cap(logic sgn, logic neg);
    if (!sgn) begin
      return '1;
    end
    return {1'b0, {63{1'b1}}} + 64'(neg);
  endfunction

  function automatic void add_digit(logic [63:0] d, logic [63:0] b);
    logic [63:0] lim;
    lim = acc_cap(c_signed, p_minus);
    if (p_mag > (lim - d) / b) begin
      p_failed = 1'b1;
    end else begin
      p_mag   = p_mag * b + d;
      p_phase = itp_pkg::PH_DIGIT;
    end
  endfunction

  function automatic void parse_char(logic [itp_pkg::CHAR_W-1:0] c);
    logic [63:0] b, d;
    logic ws;
    if (c_radix < itp_pkg::RADIX_MIN) b = 64'(itp_pkg::RADIX_MIN);
    else if (c_radix > itp_pkg::RADIX_MAX) b = 64'(itp_pkg::RADIX_MAX);
    else b = 64'(c_radix);
    d = NO_DIGIT;
    if (c >= itp_pkg::CH_ZERO && c <= itp_pkg::CH_NINE) begin
      d = 64'(c - itp_pkg::CH_ZERO);
    end else if (c >= itp_pkg::CH_LC_A && c <= itp_pkg::CH_LC_Z) begin
      d = 64'(c - itp_pkg::CH_LC_A + itp_pkg::LETTER_BASE);
    end else if (c >= itp_pkg::CH_UC_A && c <= itp_pkg::CH_UC_Z) begin
      d = 64'(c - itp_pkg::CH_UC_A + itp_pkg::LETTER_BASE);
    end
    if (d >= b) d = NO_DIGIT;
    ws = (c >= itp_pkg::CH_WS_LO && c <= itp_pkg::CH_WS_HI);
    if (p_failed) return;
    case (p_phase)
      itp_pkg::PH_LEAD: begin
        if (!ws) begin
          if (c == itp_pkg::CH_MINUS && c_signed) begin
            p_minus = 1'b1;
            p_phase = itp_pkg::PH_SIGN;
          end else if (c == itp_pkg::CH_PLUS) begin
            p_phase = itp_pkg::PH_SIGN;
          end else if (d != NO_DIGIT) begin
            add_digit(d, b);
          end else begin
            p_failed = 1'b1;
          end
        end
      end
      itp_pkg::PH_SIGN: begin
        if (d != NO_DIGIT) add_digit(d, b);
        else p_failed = 1'b1;
      end
      itp_pkg::PH_DIGIT: begin
        if (d != NO_DIGIT) add_digit(d, b);
        else if (ws) p_phase = itp_pkg::PH_TRAIL;
        else p_failed = 1'b1;
      end
      default: begin
        if (!ws) p_failed = 1'b1;
      end
    endcase
  endfunction

  function automatic parse_result_t finish_string();
    parse_result_t r;
    logic fits;
    int w;
    w = 8 << c_size;
    fits = 1'b1;
    if (p_minus && !c_signed) begin
      fits = 1'b0;
    end else if (p_mag > acc_cap(c_signed, p_minus)) begin
      fits = 1'b0;
    end else if (c_size != itp_pkg::SIZE_64) begin
      if (c_signed) fits = (p_mag <= (64'd1 << (w - 1)) - 1 + 64'(p_minus));
      else fits = (p_mag <= (64'd1 << w) - 1);
    end
    r.ok = !p_failed && (p_phase == itp_pkg::PH_DIGIT || p_phase == itp_pkg::PH_TRAIL)
           && fits;
    r.value = r.ok ? (p_minus ? 64'd0 - p_mag : p_mag) : '0;
    p_phase  = itp_pkg::PH_LEAD;
    p_failed = 1'b0;
    p_minus  = 1'b0;
    p_mag    = '0;
    return r;
  endfunction

  // ---------------- configuration port ----------------
  task automatic cfg_access(input logic wr, input itp_pkg::reg_idx_t idx,
                            input logic [itp_pkg::CFG_DW-1:0] wdata,
                            output logic [itp_pkg::CFG_DW-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_reg(itp_pkg::reg_idx_t idx);
    logic [itp_pkg::CFG_DW-1:0] rd, want;
    want = '0;
    case (idx)
      itp_pkg::REG_RADIX:  want[itp_pkg::RADIX_W-1:0] = c_radix;
      itp_pkg::REG_SIGNED: want[0] = c_signed;
      itp_pkg::REG_SIZE:   want[itp_pkg::SIZE_W-1:0] = c_size;
      default: ;
    endcase
    cfg_access(1'b0, idx, '0, rd);
    if (rd !== want) report_mismatch("register readback", 64'(want), 64'(rd));
  endtask

  task automatic cfg_set(itp_pkg::reg_idx_t idx, logic [itp_pkg::CFG_DW-1:0] v);
    logic [itp_pkg::CFG_DW-1:0] rd;
    cfg_access(1'b1, idx, v, rd);
    case (idx)
      itp_pkg::REG_RADIX:  c_radix = v[itp_pkg::RADIX_W-1:0];
      itp_pkg::REG_SIGNED: c_signed = v[0];
      itp_pkg::REG_SIZE:   c_size = itp_pkg::size_t'(v[itp_pkg::SIZE_W-1:0]);
      default: ;
    endcase
    cfg_writes++;
    check_reg(idx);
  endtask

  // ---------------- stimulus helpers ----------------
  function automatic void push_char(logic [itp_pkg::CHAR_W-1:0] c);
    char_q.push_back('{ch: c, last: 1'b0});
    pushed++;
  endfunction

  function automatic void push_end();
    char_q.push_back('{ch: 8'($urandom), last: 1'b1});
    pushed++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  function automatic logic [itp_pkg::CHAR_W-1:0] digit_char(logic [63:0] d);
    if (d < 10) return itp_pkg::CH_ZERO + d[7:0];
    return ($urandom_range(0, 1) ? itp_pkg::CH_LC_A : itp_pkg::CH_UC_A) + d[7:0]
           - itp_pkg::LETTER_BASE;
  endfunction

  // mostly well-formed strings near the interesting limits, some noise
  task automatic gen_string();
    logic [itp_pkg::CHAR_W-1:0] s[$];
    logic [63:0] mag, lim, v, bb;
    int b, w, r, n;
    logic neg, plus, extra;
    b = (c_radix < itp_pkg::RADIX_MIN) ? int'(itp_pkg::RADIX_MIN)
      : (c_radix > itp_pkg::RADIX_MAX) ? int'(itp_pkg::RADIX_MAX) : int'(c_radix);
    bb = 64'(b);
    w = 8 << c_size;
    r = $urandom_range(0, 99);
    if (c_signed) begin
      neg  = (r < 40);
      plus = (r >= 40 && r < 55);
      lim  = (w == 64) ? {1'b0, {63{1'b1}}} + 64'(neg) : (64'd1 << (w - 1)) - 1 + 64'(neg);
    end else begin
      neg  = (r < 5);
      plus = (r >= 5 && r < 20);
      lim  = (w == 64) ? '1 : (64'd1 << w) - 1;
    end
    extra = 1'b0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: mag = 64'($urandom_range(0, b * b));
      4: mag = lim;
      5: mag = lim + 1;
      6: mag = lim - 1;
      7: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
      8: mag = {1'b0, {63{1'b1}}} + 64'($urandom_range(0, 1));
      default: begin
        mag = {$urandom, $urandom};
        extra = 1'b1;
      end
    endcase
    v = mag;
    do begin
      s.push_front(digit_char(v % bb));
      v = v / bb;
    end while (v != 0);
    if ($urandom_range(0, 7) == 0) s.push_front(itp_pkg::CH_ZERO);
    if (extra) s.push_back(digit_char(64'($urandom_range(0, b - 1))));
    if (neg) s.push_front(itp_pkg::CH_MINUS);
    else if (plus) s.push_front(itp_pkg::CH_PLUS);
    n = $urandom_range(0, 2);
    repeat (n) s.push_front(8'($urandom_range(itp_pkg::CH_WS_LO, itp_pkg::CH_WS_HI)));
    n = $urandom_range(0, 2);
    repeat (n) s.push_back(8'($urandom_range(itp_pkg::CH_WS_LO, itp_pkg::CH_WS_HI)));
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
        1: s.insert($urandom_range(0, s.size()),
                    $urandom_range(0, 1) ? CH_SPACE : 8'($urandom));
        2: begin
          s.delete();
          if ($urandom_range(0, 1)) begin
            s.push_back(8'($urandom_range(itp_pkg::CH_WS_LO, itp_pkg::CH_WS_HI)));
          end
          if ($urandom_range(0, 1)) begin
            s.push_back($urandom_range(0, 1) ? itp_pkg::CH_MINUS : itp_pkg::CH_PLUS);
          end
        end
        default: begin
          s.delete();
          repeat ($urandom_range(1, 6)) s.push_back(8'($urandom));
        end
      endcase
    end
    foreach (s[i]) push_char(s[i]);
    push_end();
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (char_q.size() != 0 || in_tvalid || want_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // ---------------- input driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap > 0) begin
        in_tvalid <= 1'b0;
        tx_gap    <= tx_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_tvalid <= 1'b0;
        tx_gap    <= $urandom_range(0, 4);
      end else if (char_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= char_q[0].ch;
        in_tlast  <= char_q[0].last;
        void'(char_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- output ready, with one long hold-off ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap     <= 0;
      hold_cnt   <= 0;
      press_done <= 1'b0;
    end else if (press_on && !press_done) begin
      out_tready <= 1'b0;
      hold_cnt   <= HOLD_CYCLES;
      press_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else if (rx_gap > 0) begin
      out_tready <= 1'b0;
      rx_gap     <= rx_gap - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      rx_gap     <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------- transfer monitor and checker ----------------
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        chars_in++;
        if (in_tlast) want_q.push_back(finish_string());
        else parse_char(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (want_q.size() == 0) begin
          report_mismatch("unexpected result", '0, out_tdata);
        end else begin
          want = want_q.pop_front();
          strings_done++;
          if (out_tdata !== want.value) report_mismatch("parsed_value", want.value, out_tdata);
          if (out_tuser[0] !== want.ok) begin
            report_mismatch("parse_ok", 64'(want.ok), 64'(out_tuser[0]));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL integer_text_parser");
      $finish;
    end
  end

  initial begin
    int start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 3; i++) check_reg(itp_pkg::reg_idx_t'(i));

    // directed strings under reset settings
    push_end();
    push_char(itp_pkg::CH_WS_LO); push_char(itp_pkg::CH_WS_HI); push_end();
    push_char(itp_pkg::CH_MINUS); push_end();
    push_char(8'h00); push_end();
    push_char(8'hFF); push_end();
    push_char(itp_pkg::CH_WS_HI); push_char(itp_pkg::CH_PLUS); push_text("7");
    push_char(8'(itp_pkg::CH_WS_LO + 1));
    push_end();
    push_text("1x9"); push_end();
    // minus taken in signed mode, string ended after switching to unsigned
    push_text("-5");
    wait_idle();
    cfg_set(itp_pkg::REG_SIGNED, 0);
    push_end();
    wait_idle();
    cfg_set(itp_pkg::REG_SIGNED, 1);
    cfg_set(itp_pkg::REG_RADIX, 36);
    push_text("-1y2P0iJ32e8E8"); push_end();

    for (int p = 0; p < 12; p++) begin
      wait_idle();
      cfg_set(itp_pkg::REG_RADIX, radix_tab[p]);
      cfg_set(itp_pkg::REG_SIGNED, p % 2);
      cfg_set(itp_pkg::REG_SIZE, (p / 2) % 4);
      if (p == 3) press_on <= 1'b1;
      if (p == 10) calm <= 1'b1;
      start = pushed;
      while (pushed - start < PHASE_ITEMS) gen_string();
    end

    wait_idle();
    repeat (16) @(posedge clk);
    $display("%0d characters in, %0d parsed strings checked, %0d register writes",
             chars_in, strings_done, cfg_writes);
    $display("radix 0..63, both sign modes, all result widths, %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("PASS integer_text_parser");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL integer_text_parser");
    end
    $finish;
  end

endmodule
